// ----- src/calu_pkg.sv -----
// Shared operation codes, flag positions and pipeline types for the ALU.
package calu_pkg;

	localparam logic [4:0] OP_ADD8  = 5'd0;
	localparam logic [4:0] OP_ADC8  = 5'd1;
	localparam logic [4:0] OP_SUB8  = 5'd2;
	localparam logic [4:0] OP_SBC8  = 5'd3;
	localparam logic [4:0] OP_ADD16 = 5'd4;
	localparam logic [4:0] OP_ADC16 = 5'd5;
	localparam logic [4:0] OP_SUB16 = 5'd6;
	localparam logic [4:0] OP_SBC16 = 5'd7;
	localparam logic [4:0] OP_AND   = 5'd8;
	localparam logic [4:0] OP_OR    = 5'd9;
	localparam logic [4:0] OP_XOR   = 5'd10;
	localparam logic [4:0] OP_INC8  = 5'd11;
	localparam logic [4:0] OP_INC16 = 5'd12;
	localparam logic [4:0] OP_DEC8  = 5'd13;
	localparam logic [4:0] OP_DEC16 = 5'd14;
	localparam logic [4:0] OP_SAL   = 5'd15;
	localparam logic [4:0] OP_SHL   = 5'd16;
	localparam logic [4:0] OP_SAR   = 5'd17;
	localparam logic [4:0] OP_SHR   = 5'd18;
	localparam logic [4:0] OP_ROLC  = 5'd19;
	localparam logic [4:0] OP_ROL   = 5'd20;
	localparam logic [4:0] OP_RORC  = 5'd21;
	localparam logic [4:0] OP_ROR   = 5'd22;
	localparam logic [4:0] OP_NOT   = 5'd23;
	localparam logic [4:0] OP_NEG   = 5'd24;
	localparam logic [4:0] OP_SWAP  = 5'd25;
	localparam logic [4:0] OP_MUL   = 5'd26;
	localparam logic [4:0] OP_DIV   = 5'd27;

	localparam int FZ = 0;
	localparam int FC = 1;
	localparam int FO = 2;
	localparam int FS = 3;

	localparam int DIV_STEPS = 4;

	typedef struct packed {
		logic [15:0] rem;
		logic [7:0]  quo;
		logic [7:0]  dvs;
		logic [3:0]  flags;
		logic [15:0] dvd;
		logic        is_div;
		logic        dz;
		logic        ovf;
	} div_state_t;

endpackage

// ----- src/calu_div_stage.sv -----
// One registered stage of the restoring divider: retires two quotient bits.
module calu_div_stage (
	input  logic                     clk,
	input  logic                     adv,
	input  logic                     v_in,
	input  calu_pkg::div_state_t     d_in,
	output calu_pkg::div_state_t     d_out
);

	calu_pkg::div_state_t nxt;
	logic [16:0] t0;
	logic [16:0] t1;
	logic [15:0] r0;

	always_comb begin
		nxt = d_in;
		t0 = {d_in.rem, d_in.quo[7]} - {9'd0, d_in.dvs};
		r0 = t0[16] ? {d_in.rem[14:0], d_in.quo[7]} : t0[15:0];
		t1 = {r0, d_in.quo[6]} - {9'd0, d_in.dvs};
		nxt.rem = t1[16] ? {r0[14:0], d_in.quo[6]} : t1[15:0];
		nxt.quo = {d_in.quo[5:0], ~t0[16], ~t1[16]};
	end

	always_ff @(posedge clk) begin
		if (adv && v_in) begin
			d_out <= nxt;
		end
	end

endmodule

// ----- src/cpu_alu_with_bcd_and_nibble_modes.sv -----
// Top level of the ALU pipeline with decimal and nibble modes.
// One request may enter every cycle unless in_stall is raised. The depth is set by the divider,
// which retires two quotient bits in each of four stages after an operand stage; all other
// operations are computed in the first stage and ride alongside. A stalled output holds the
// whole pipeline while its last stage holds a result, and the pipeline takes a new request
// while its last stage is empty even when the output is stalled.
module cpu_alu_with_bcd_and_nibble_modes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  operation,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic [3:0]  flags_in,
	input  logic        decimal_mode,
	input  logic        unpack_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result,
	output logic [3:0]  flags_out,
	output logic        divide_by_zero
);

	localparam int N = calu_pkg::DIV_STEPS;

	logic [N:0]   v_q;
	logic         adv;
	logic [15:0]  res_c;
	logic [3:0]   f_c;
	logic [15:0]  res_s1;
	logic [3:0]   f_s1;
	logic [15:0]  res_p_q [N];
	logic [3:0]   f_p_q [N];
	logic [15:0]  mul_s1;
	calu_pkg::div_state_t d_s1;
	calu_pkg::div_state_t d_st [N];
	logic [7:0]   a8, b8;
	logic         cin;
	logic         op_mul_s1;

	assign adv = !(v_q[N] && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_q[N];

	assign a8 = operand_a[7:0];
	assign b8 = operand_b[7:0];
	assign cin = flags_in[calu_pkg::FC];

	function automatic logic [3:0] putf(logic [3:0] f, int i, logic v);
		logic [3:0] g;
		g = f;
		g[i] = v;
		return g;
	endfunction

	always_comb begin
		logic        sub, c, cy;
		logic [8:0]  r9;
		logic [4:0]  r5;
		logic [7:0]  r8;
		logic [7:0]  m;
		logic [5:0]  lo, hi;
		logic [16:0] r17;
		res_c = '0;
		f_c = flags_in;
		sub = 1'b0; c = 1'b0; cy = 1'b0;
		r9 = '0; r5 = '0; r8 = '0; m = '0; lo = '0; hi = '0; r17 = '0;
		case (operation)
			calu_pkg::OP_ADD8, calu_pkg::OP_ADC8, calu_pkg::OP_SUB8,
			calu_pkg::OP_SBC8: begin
				sub = operation[1];
				c = operation[0] & cin;
				if (!decimal_mode) begin
					if (unpack_mode) begin
						r5 = sub ? ({1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, c})
						         : ({1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, c});
						r8 = {4'd0, r5[3:0]};
						cy = r5[4];
						m = 8'h08;
						f_c = putf(f_c, calu_pkg::FO, sub ?
							(((a8[3] ^ b8[3]) && (a8[3] ^ r8[3]))) :
							(!(a8[3] ^ b8[3]) && (a8[3] ^ r8[3])));
					end else begin
						r9 = sub ? ({1'b0, a8} - {1'b0, b8} - {8'd0, c})
						         : ({1'b0, a8} + {1'b0, b8} + {8'd0, c});
						r8 = r9[7:0];
						cy = r9[8];
						m = 8'h80;
						f_c = putf(f_c, calu_pkg::FO, sub ?
							(((a8[7] ^ b8[7]) && (a8[7] ^ r8[7]))) :
							(!(a8[7] ^ b8[7]) && (a8[7] ^ r8[7])));
					end
					f_c = putf(f_c, calu_pkg::FS, (r8 & m) != 8'd0);
				end else begin
					if (sub) begin
						lo = {2'b0, a8[3:0]} - {2'b0, b8[3:0]} - {5'd0, c};
						cy = lo > 6'h0F;
						if (cy) lo = lo - 6'h06;
					end else begin
						lo = {2'b0, a8[3:0]} + {2'b0, b8[3:0]} + {5'd0, c};
						if (lo > 6'h09) lo = lo + 6'h06;
						cy = lo > 6'h0F;
					end
					if (unpack_mode) begin
						r8 = {4'd0, lo[3:0]};
					end else begin
						if (sub) begin
							hi = {2'b0, a8[7:4]} - {2'b0, b8[7:4]} - {5'd0, cy};
							cy = hi > 6'h0F;
							if (cy) hi = hi - 6'h06;
						end else begin
							hi = {2'b0, a8[7:4]} + {2'b0, b8[7:4]} + {5'd0, cy};
							if (hi > 6'h09) hi = hi + 6'h06;
							cy = hi > 6'h0F;
						end
						r8 = {hi[3:0], lo[3:0]};
					end
					f_c = putf(f_c, calu_pkg::FO, 1'b0);
					f_c = putf(f_c, calu_pkg::FS, 1'b0);
				end
				res_c = {8'd0, r8};
				f_c = putf(f_c, calu_pkg::FZ, r8 == 8'd0);
				f_c = putf(f_c, calu_pkg::FC, cy);
			end
			calu_pkg::OP_ADD16, calu_pkg::OP_ADC16, calu_pkg::OP_SUB16,
			calu_pkg::OP_SBC16: begin
				sub = operation[1];
				c = operation[0] & cin;
				r17 = sub ? ({1'b0, operand_a} - {1'b0, operand_b} - {16'd0, c})
				          : ({1'b0, operand_a} + {1'b0, operand_b} + {16'd0, c});
				res_c = r17[15:0];
				f_c = putf(f_c, calu_pkg::FZ, r17[15:0] == 16'd0);
				f_c = putf(f_c, calu_pkg::FC, r17[16]);
				f_c = putf(f_c, calu_pkg::FO, sub ?
					((operand_a[15] ^ operand_b[15]) && (operand_a[15] ^ r17[15])) :
					(!(operand_a[15] ^ operand_b[15]) && (operand_a[15] ^ r17[15])));
				f_c = putf(f_c, calu_pkg::FS, r17[15]);
			end
			calu_pkg::OP_AND, calu_pkg::OP_OR, calu_pkg::OP_XOR, calu_pkg::OP_NOT,
			calu_pkg::OP_SAL, calu_pkg::OP_SHL, calu_pkg::OP_SAR, calu_pkg::OP_SHR,
			calu_pkg::OP_ROLC, calu_pkg::OP_ROL, calu_pkg::OP_RORC, calu_pkg::OP_ROR,
			calu_pkg::OP_NEG: begin
				case (operation)
					calu_pkg::OP_AND:  r8 = a8 & b8;
					calu_pkg::OP_OR:   r8 = a8 | b8;
					calu_pkg::OP_XOR:  r8 = a8 ^ b8;
					calu_pkg::OP_NOT:  r8 = ~a8;
					calu_pkg::OP_SAL, calu_pkg::OP_SHL: r8 = {a8[6:0], 1'b0};
					calu_pkg::OP_SAR:  r8 = {a8[7], a8[7:1]};
					calu_pkg::OP_SHR:  r8 = {1'b0, a8[7:1]};
					calu_pkg::OP_ROLC: r8 = {a8[6:0], cin};
					calu_pkg::OP_ROL:  r8 = {a8[6:0], a8[7]};
					calu_pkg::OP_RORC: r8 = {cin, a8[7:1]};
					calu_pkg::OP_ROR:  r8 = {a8[0], a8[7:1]};
					calu_pkg::OP_NEG:  r8 = 8'd0 - a8;
					default:           r8 = '0;
				endcase
				res_c = {8'd0, r8};
				f_c = putf(f_c, calu_pkg::FZ, r8 == 8'd0);
				f_c = putf(f_c, calu_pkg::FS, r8[7]);
				case (operation)
					calu_pkg::OP_SAL, calu_pkg::OP_SHL, calu_pkg::OP_ROLC,
					calu_pkg::OP_ROL: f_c = putf(f_c, calu_pkg::FC, a8[7]);
					calu_pkg::OP_SAR, calu_pkg::OP_SHR, calu_pkg::OP_RORC,
					calu_pkg::OP_ROR: f_c = putf(f_c, calu_pkg::FC, a8[0]);
					calu_pkg::OP_NEG: f_c = putf(f_c, calu_pkg::FC, r8 != 8'd0);
					default: ;
				endcase
				if (operation == calu_pkg::OP_SAL)
					f_c = putf(f_c, calu_pkg::FO, a8[7] ^ r8[7]);
				if (operation == calu_pkg::OP_SAR)
					f_c = putf(f_c, calu_pkg::FO, 1'b0);
				if (operation == calu_pkg::OP_NEG)
					f_c = putf(f_c, calu_pkg::FO, r8 == 8'h80);
			end
			calu_pkg::OP_INC8, calu_pkg::OP_DEC8: begin
				r8 = (operation == calu_pkg::OP_INC8) ? a8 + 8'd1 : a8 - 8'd1;
				res_c = {8'd0, r8};
				f_c = putf(f_c, calu_pkg::FZ, r8 == 8'd0);
			end
			calu_pkg::OP_INC16, calu_pkg::OP_DEC16: begin
				res_c = (operation == calu_pkg::OP_INC16) ? operand_a + 16'd1
				                                          : operand_a - 16'd1;
				f_c = putf(f_c, calu_pkg::FZ, res_c == 16'd0);
			end
			calu_pkg::OP_SWAP: res_c = {8'd0, a8[3:0], a8[7:4]};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			res_s1    <= res_c;
			f_s1      <= f_c;
			mul_s1    <= {8'd0, a8} * {8'd0, b8};
			op_mul_s1 <= operation == calu_pkg::OP_MUL;
			d_s1.rem  <= {8'd0, operand_a[15:8]};
			d_s1.quo  <= operand_a[7:0];
			d_s1.dvs  <= b8;
			d_s1.flags <= flags_in;
			d_s1.dvd  <= operand_a;
			d_s1.is_div <= operation == calu_pkg::OP_DIV;
			d_s1.dz   <= b8 == 8'd0;
			d_s1.ovf  <= operand_a[15:8] >= b8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_q[0]) begin
			res_p_q[0] <= op_mul_s1 ? mul_s1 : res_s1;
			f_p_q[0]   <= op_mul_s1 ? {mul_s1[15], 1'b0, 1'b0, mul_s1 == 16'd0} : f_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < N; i++) begin
			if (adv && v_q[i]) begin
				res_p_q[i] <= res_p_q[i-1];
				f_p_q[i]   <= f_p_q[i-1];
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_div
			calu_div_stage u_stage (
				.clk  (clk),
				.adv  (adv),
				.v_in (v_q[g]),
				.d_in ((g == 0) ? d_s1 : d_st[(g == 0) ? 0 : g - 1]),
				.d_out(d_st[g])
			);
		end
	endgenerate

	calu_pkg::div_state_t dl;
	assign dl = d_st[N-1];

	always_comb begin
		result = res_p_q[N-1];
		flags_out = f_p_q[N-1];
		divide_by_zero = 1'b0;
		if (dl.is_div) begin
			if (dl.dz) begin
				result = dl.dvd;
				flags_out = dl.flags;
				divide_by_zero = 1'b1;
			end else if (dl.ovf) begin
				result = dl.dvd;
				flags_out = 4'b1100;
			end else begin
				result = {dl.rem[7:0], dl.quo};
				flags_out = {dl.quo[7], 1'b0, 1'b0, dl.quo == 8'd0};
			end
		end
	end

endmodule
